[rtl/fvn3_pkg.sv]
// Package for the 3D fractal value noise block.
// Holds the hash constants and payload widths; depends on nothing.
package fvn3_pkg;

  localparam logic [31:0] HashX    = 32'd374761393;
  localparam logic [31:0] HashY    = 32'd668265263;
  localparam logic [31:0] HashZ    = 32'd2246822519;
  localparam logic [31:0] HashSeed = 32'd3266489917;
  localparam logic [31:0] HashMix  = 32'd1274126177;

  localparam int unsigned CoordW = 32;
  localparam int unsigned NoiseW = 16;

  // Corner values and blends in signed Q1.15 with one guard bit.
  typedef logic signed [16:0] val_t;
  // Fade weight in Q0.16, 0..65536.
  typedef logic [16:0] wgt_t;

endpackage

[rtl/fractal_value_noise_3d.sv]
// Top level of the 3D fractal value noise block: octave lanes, sum, divide.
// Depends on fvn3_pkg for hash constants and types.
//
// Throughput: one transaction per cycle while the output is not stalled;
// each stage ends in its register, and empty stages fill while the output
// stalls.
// Reset clears the stage valid bits and sets seed_base to zero.
module fractal_value_noise_3d #(
  parameter int unsigned OCTAVES   = 2,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [fvn3_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [fvn3_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [fvn3_pkg::CoordW-1:0] coord_z_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fvn3_pkg::NoiseW-1:0]    noise_value_o,
  // seed_base write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [31:0]                    cfg_data_i
);

  // Stage count: 8 per-octave stages, then sum, reciprocal multiply, output.
  localparam int unsigned NumStages = 11;
  localparam int unsigned ProdW     = FRAC_BITS + 32;
  localparam int unsigned FracUp    = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
  localparam int unsigned FracDown  = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
  // Total octave amplitude and its reciprocal; exact for sums below 2^16 * T.
  localparam longint unsigned Total = (64'd1 << OCTAVES) - 64'd1;
  localparam longint unsigned RecipL = ((64'd1 << 32) + Total - 64'd1) / Total;
  localparam logic [32:0] Recip = 33'(RecipL);
  localparam int unsigned SumW = 17 + OCTAVES;
  localparam int unsigned NumW = 26;
  localparam logic signed [NumW-1:0] NumBias =
    NumW'(signed'(65'(32768 * Total + Total / 2)));

  logic [31:0] seed_q;
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      v_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        seed_q <= cfg_data_i;
      end
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // a + floor(((b - a) * w + 2^15) / 2^16)
  function automatic fvn3_pkg::val_t blend(fvn3_pkg::val_t a, fvn3_pkg::val_t b,
                                           fvn3_pkg::wgt_t w);
    logic signed [17:0] d;
    logic signed [36:0] p;
    d = 18'(b) - 18'(a);
    p = 37'(d) * 37'(signed'({1'b0, w})) + 37'sd32768;
    return 17'(a + 17'(p >>> 16));
  endfunction

  localparam int unsigned CoordW_l = fvn3_pkg::CoordW;
  logic signed [CoordW_l-1:0] crd [3];
  assign crd[0] = coord_x_i;
  assign crd[1] = coord_y_i;
  assign crd[2] = coord_z_i;

  fvn3_pkg::val_t n_q [OCTAVES];

  for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
    localparam logic [10:0] Scale = 11'(5 << g);

    logic [31:0] idx_d [3];
    logic [15:0] frac_d [3];
    logic [31:0] idx_q [3];
    logic [15:0] frac_q [3];
    logic [31:0] smul_q, smul2_q;
    logic [31:0] hx_q [3][2];
    logic [15:0] t_q [3];
    logic [31:0] t2_q [3];
    logic [31:0] h_q [8];
    logic [31:0] t3_q [3];
    logic [20:0] p16_q [3];
    logic [31:0] hm_q [8];
    logic [52:0] fp_q [3];
    fvn3_pkg::val_t cv_q [8];
    fvn3_pkg::wgt_t fd_q [3];
    fvn3_pkg::val_t xb_q [4];
    fvn3_pkg::wgt_t v6_q, w6_q, w7_q;
    fvn3_pkg::val_t yb_q [2];

    // Scale the point and split into lattice index and Q0.16 fraction.
    always_comb begin
      logic signed [ProdW-1:0] pr;
      logic [39:0] fw;
      for (int a = 0; a < 3; a++) begin
        pr = ProdW'(crd[a]) * ProdW'(signed'({1'b0, Scale}));
        idx_d[a]  = pr[FRAC_BITS +: 32];
        fw        = 40'(pr[FRAC_BITS-1:0]);
        frac_d[a] = 16'((fw << FracUp) >> FracDown);
      end
    end

    always_ff @(posedge clk_i) begin
      logic [31:0] h;
      logic [36:0] p;
      logic [21:0] f;
      logic [2:0]  c;
      if (en[0]) begin
        idx_q  <= idx_d;
        frac_q <= frac_d;
        smul_q <= 32'((seed_q + 32'(g)) * fvn3_pkg::HashSeed);
      end
      if (en[1]) begin
        for (int a = 0; a < 3; a++) begin
          t_q[a]  <= frac_q[a];
          t2_q[a] <= 32'(frac_q[a]) * 32'(frac_q[a]);
        end
        hx_q[0][0] <= idx_q[0] * fvn3_pkg::HashX;
        hx_q[0][1] <= (idx_q[0] + 32'd1) * fvn3_pkg::HashX;
        hx_q[1][0] <= idx_q[1] * fvn3_pkg::HashY;
        hx_q[1][1] <= (idx_q[1] + 32'd1) * fvn3_pkg::HashY;
        hx_q[2][0] <= idx_q[2] * fvn3_pkg::HashZ;
        hx_q[2][1] <= (idx_q[2] + 32'd1) * fvn3_pkg::HashZ;
        smul2_q    <= smul_q;
      end
      if (en[2]) begin
        for (int k = 0; k < 8; k++) begin
          c = 3'(k);
          h = hx_q[0][c[0]] ^ hx_q[1][c[1]] ^ hx_q[2][c[2]] ^ smul2_q;
          h_q[k] <= h ^ (h >> 13);
        end
        for (int a = 0; a < 3; a++) begin
          t3_q[a] <= 32'((48'(t2_q[a]) * 48'(t_q[a])) >> 16);
          p = 37'd6 * 37'(t2_q[a]) + (37'd10 << 32) - ((37'd15 * 37'(t_q[a])) << 16);
          p16_q[a] <= p[36:16];
        end
      end
      if (en[3]) begin
        for (int k = 0; k < 8; k++) begin
          hm_q[k] <= h_q[k] * fvn3_pkg::HashMix;
        end
        for (int a = 0; a < 3; a++) begin
          fp_q[a] <= 53'(t3_q[a]) * 53'(p16_q[a]);
        end
      end
      if (en[4]) begin
        // Upper half survives the final xor-shift untouched.
        for (int k = 0; k < 8; k++) begin
          cv_q[k] <= signed'({1'b0, hm_q[k][31:16]}) - 17'sd32768;
        end
        for (int a = 0; a < 3; a++) begin
          f = 22'((fp_q[a] + 53'(64'd1 << 31)) >> 32);
          fd_q[a] <= (f > 22'd65536) ? 17'd65536 : 17'(f);
        end
      end
      if (en[5]) begin
        for (int j = 0; j < 4; j++) begin
          xb_q[j] <= blend(cv_q[2*j], cv_q[2*j+1], fd_q[0]);
        end
        v6_q <= fd_q[1];
        w6_q <= fd_q[2];
      end
      if (en[6]) begin
        yb_q[0] <= blend(xb_q[0], xb_q[1], v6_q);
        yb_q[1] <= blend(xb_q[2], xb_q[3], v6_q);
        w7_q    <= w6_q;
      end
      if (en[7]) begin
        n_q[g] <= blend(yb_q[0], yb_q[1], w7_q);
      end
    end
  end

  logic signed [NumW-1:0] num_q;
  logic [57:0] qp_q;
  logic [fvn3_pkg::NoiseW-1:0] out_q;

  // Weighted octave sum with bias, then divide by the total amplitude.
  always_ff @(posedge clk_i) begin
    logic signed [SumW-1:0] sum;
    logic [25:0] q;
    if (en[8]) begin
      sum = '0;
      for (int i = 0; i < OCTAVES; i++) begin
        sum = sum + (SumW'(n_q[i]) <<< (OCTAVES - 1 - i));
      end
      num_q <= NumW'(sum) + NumBias;
    end
    if (en[9]) begin
      qp_q <= 58'(unsigned'(num_q[NumW-2:0])) * 58'(Recip);
    end
    if (en[10]) begin
      q = qp_q[57:32];
      out_q <= (q > 26'd65535) ? 16'hFFFF : q[15:0];
    end
  end

  assign out_valid_o   = v_q[NumStages-1];
  assign noise_value_o = out_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for fractal_value_noise_3d: drives coordinates, predicts
// the noise value per transaction and compares in order. Depends on fvn3_pkg.
module testbench;

  localparam int unsigned OCTAVES   = 2;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LATENCY   = 11;
  localparam int          N_RANDOM  = 950;

  typedef struct packed {
    logic signed [fvn3_pkg::CoordW-1:0] x;
    logic signed [fvn3_pkg::CoordW-1:0] y;
    logic signed [fvn3_pkg::CoordW-1:0] z;
  } point_t;

  // Directed row: point, and an expected value where one is known at a glance.
  typedef struct {
    point_t                      pt;
    bit                          known;
    logic [fvn3_pkg::NoiseW-1:0] value;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [fvn3_pkg::CoordW-1:0] coord_x_i = '0;
  logic signed [fvn3_pkg::CoordW-1:0] coord_y_i = '0;
  logic signed [fvn3_pkg::CoordW-1:0] coord_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [fvn3_pkg::NoiseW-1:0] noise_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  logic [31:0]                 seed_base_q;   // predictor copy of the seed register
  logic [fvn3_pkg::NoiseW-1:0] noise_expected_q[$];
  int                          mismatch_count = 0;
  bit                          hold_off_req = 1'b0;

  always #5 clk_i = ~clk_i;

  fractal_value_noise_3d #(
    .OCTAVES  (OCTAVES),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .noise_value_o(noise_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Noise predictor
  // ---------------------------------------------------------------------------

  // Quintic fade of a Q0.16 fraction, rounded, capped at one.
  function automatic logic [16:0] fade_weight(logic [15:0] t);
    logic [63:0] t64, t2, t3, p, f;
    t64 = {48'd0, t};
    t2  = t64 * t64;
    t3  = (t2 * t64) >> 16;
    p   = 64'd6 * t2 + (64'd10 << 32) - 64'd15 * (t64 << 16);
    f   = (t3 * (p >> 16) + (64'd1 << 31)) >> 32;
    if (f > 64'd65536) f = 64'd65536;
    return f[16:0];
  endfunction

  // Hash one lattice corner to signed Q1.15.
  function automatic int lattice_value(logic [31:0] seed, logic [31:0] xi,
                                       logic [31:0] yi, logic [31:0] zi);
    logic [31:0] h;
    h = (xi * fvn3_pkg::HashX) ^ (yi * fvn3_pkg::HashY) ^ (zi * fvn3_pkg::HashZ) ^
        (seed * fvn3_pkg::HashSeed);
    h = h ^ (h >> 13);
    h = h * fvn3_pkg::HashMix;
    h = h ^ (h >> 16);
    return int'({16'd0, h[31:16]}) - 32768;
  endfunction

  // a + floor(((b - a) * w + half) / 2^16), arithmetic shift is floor.
  function automatic int lerp_q16(int a, int b, logic [16:0] w);
    longint d;
    d = (longint'(b) - longint'(a)) * longint'({47'd0, w}) + 64'sd32768;
    return a + int'(d >>> 16);
  endfunction

  // Scale by 5 * 2^octave; lattice index wraps, fraction cut to Q0.16.
  function automatic void split_coord(logic signed [31:0] c, int octave,
                                      output logic [31:0] idx,
                                      output logic [15:0] fr);
    logic [63:0] s, f;
    s   = 64'(longint'(c)) * (64'd5 << octave);
    f   = s & ((64'd1 << FRAC_BITS) - 1);
    idx = 32'(s >> FRAC_BITS);
    if (FRAC_BITS >= 16) f = f >> (FRAC_BITS - 16);
    else f = f << (16 - FRAC_BITS);
    fr  = f[15:0];
  endfunction

  function automatic int octave_value(logic [31:0] seed, point_t pt, int octave);
    logic [31:0] xi, yi, zi;
    logic [15:0] xf, yf, zf;
    logic [16:0] u, v, w;
    int x00, x10, x01, x11, y0, y1;
    split_coord(pt.x, octave, xi, xf);
    split_coord(pt.y, octave, yi, yf);
    split_coord(pt.z, octave, zi, zf);
    u = fade_weight(xf);
    v = fade_weight(yf);
    w = fade_weight(zf);
    x00 = lerp_q16(lattice_value(seed, xi, yi, zi),
                   lattice_value(seed, xi + 1, yi, zi), u);
    x10 = lerp_q16(lattice_value(seed, xi, yi + 1, zi),
                   lattice_value(seed, xi + 1, yi + 1, zi), u);
    x01 = lerp_q16(lattice_value(seed, xi, yi, zi + 1),
                   lattice_value(seed, xi + 1, yi, zi + 1), u);
    x11 = lerp_q16(lattice_value(seed, xi, yi + 1, zi + 1),
                   lattice_value(seed, xi + 1, yi + 1, zi + 1), u);
    y0 = lerp_q16(x00, x10, v);
    y1 = lerp_q16(x01, x11, v);
    return lerp_q16(y0, y1, w);
  endfunction

  function automatic logic [fvn3_pkg::NoiseW-1:0] predict_noise(point_t pt);
    longint sum, total, res;
    sum   = 0;
    total = (64'sd1 << OCTAVES) - 1;
    for (int i = 0; i < OCTAVES; i++)
      sum += longint'(octave_value(seed_base_q + 32'(i), pt, i)) <<< (OCTAVES - 1 - i);
    res = (sum + 32768 * total + total / 2) / total;
    if (res > 65535) res = 65535;
    return res[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pattern, long hold-off on request, in-order compare.
  // ---------------------------------------------------------------------------

  initial begin
    int pattern;
    int hold_left;
    bit hold_done;
    pattern = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done && hold_left == 0) begin
        hold_left = 200;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        // Switch at random between no stall, light stall and heavy stall phases.
        if ($urandom_range(0, 63) == 0) pattern = $urandom_range(0, 2);
        case (pattern)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result noise_value=%0d", $time, noise_value_o);
      end else begin
        logic [fvn3_pkg::NoiseW-1:0] want;
        want = noise_expected_q.pop_front();
        if (noise_value_o !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: noise_value expected %0d got %0d", $time, want, noise_value_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  int burst_left = 0;

  // Offer one point, honoring burst gaps; hold payload until accepted.
  task automatic send_point(point_t pt, bit known, logic [fvn3_pkg::NoiseW-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    coord_x_i  <= pt.x;
    coord_y_i  <= pt.y;
    coord_z_i  <= pt.z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Accepted: record expectation now, before the result can appear.
    noise_expected_q.push_back(known ? value : predict_noise(pt));
    @(negedge clk_i);
  endtask

  // Drain all expected results, let the pipe settle, then write the seed.
  task automatic write_seed(logic [31:0] seed);
    in_valid_i <= 1'b0;
    while (noise_expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= seed;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    seed_base_q = seed;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;                                   // full range
      1: return 32'(int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return {16'($urandom), 16'hFFFF};                  // fade near one
      4: return {16'($urandom), 16'h0000};                  // on the lattice
      default: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
    endcase
  endfunction

  stim_row_t directed_rows[$];
  logic [31:0] seed_settings[5] = '{32'd0, 32'hFFFF_FFFF, 32'h0000_0001,
                                     32'h8000_0000, 32'h1234_5678};

  initial begin
    point_t pt;
    // Reset on the origin: every fraction is zero, so only corner (0,0,0)
    // matters; still predicted since hashing is not a glance computation.
    directed_rows.push_back('{'{32'sd0, 32'sd0, 32'sd0}, 1'b0, '0});
    directed_rows.push_back('{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, '0});
    directed_rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '0});
    directed_rows.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0}, 1'b0, '0});
    directed_rows.push_back('{'{-32'sd1, -32'sd1, -32'sd1}, 1'b0, '0});
    directed_rows.push_back('{'{32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF}, 1'b0, '0});
    directed_rows.push_back('{'{32'sh0000_3333, 32'sh0000_3334, 32'sh0000_1999}, 1'b0, '0});
    directed_rows.push_back('{'{32'sh0000_8000, 32'shFFFF_8000, 32'sh0001_0000}, 1'b0, '0});
    directed_rows.push_back('{'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F}, 1'b0, '0});
    directed_rows.push_back('{'{32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0}, 1'b0, '0});
    directed_rows.push_back('{'{32'sd1, -32'sd2, 32'sh4000_0000}, 1'b0, '0});

    seed_base_q = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_point(directed_rows[i].pt, directed_rows[i].known, directed_rows[i].value);

    // Random part across several seed settings, extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      write_seed(seed_settings[phase]);
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        if (phase == 2 && n == 20) hold_off_req = 1'b1;
        pt.x = rand_coord();
        pt.y = rand_coord();
        pt.z = rand_coord();
        send_point(pt, 1'b0, '0);
      end
    end
    write_seed($urandom);
    for (int n = 0; n < 10; n++) begin
      pt.x = $urandom;
      pt.y = $urandom;
      pt.z = $urandom;
      send_point(pt, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (noise_expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY * 2) @(negedge clk_i);
    if (mismatch_count == 0 && noise_expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
